FILE: design/assert_macros.svh
// assertion macros shared by the regulator rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/mbr_pkg.sv
// types, constants and helpers of the memory bandwidth regulator
package mbr_pkg;

	localparam int DELTA_W   = 24;
	localparam int ACCUM_W   = 40;
	localparam int BUDGET_W  = 48;
	localparam int QUOTA_W   = 32;
	localparam int CFG_W     = 32;
	localparam int CFG_IDX_W = 2;

	typedef logic [DELTA_W-1:0]         delta_t;
	typedef logic [ACCUM_W-1:0]         accum_t;
	typedef logic signed [BUDGET_W-1:0] budget_t;
	typedef logic [QUOTA_W-1:0]         quota_t;
	typedef logic [CFG_W-1:0]           cfg_data_t;
	typedef logic [CFG_IDX_W-1:0]       cfg_idx_t;

	// register indexes
	localparam cfg_idx_t REG_WINDOW_BUDGET   = 2'd0;
	localparam cfg_idx_t REG_RESERVE_THRESH  = 2'd1;
	localparam cfg_idx_t REG_INITIAL_QUOTA   = 2'd2;

	// register reset values
	localparam cfg_data_t RST_WINDOW_BUDGET  = 32'd60000;
	localparam cfg_data_t RST_RESERVE_THRESH = 32'd500;
	localparam quota_t    RST_INITIAL_QUOTA  = 32'd20000;

	// quota / 3 as (quota * ceil(2^33 / 3)) >> 33, exact for every 32 bit quota
	localparam int     QUOTA_SHIFT = 33;
	localparam quota_t QUOTA_RECIP = 32'hAAAA_AAAB;

	// accumulator plus delta, clamped at the accumulator maximum
	localparam int SAT_W = ((ACCUM_W > DELTA_W) ? ACCUM_W : DELTA_W) + 1;

	function automatic accum_t sat_add(input accum_t acc, input delta_t d);
		logic [SAT_W-1:0] s;
		begin
			s = SAT_W'(acc) + SAT_W'(d);
			if (s[SAT_W-1:ACCUM_W] != '0) begin
				return '1;
			end
			return s[ACCUM_W-1:0];
		end
	endfunction

endpackage

FILE: design/memory_bandwidth_regulator_unit.sv
// memory bandwidth regulator: per-tick miss accounting, quota and throttle control
//
//  channel   | valid        | stall        | payload
//  ----------+--------------+--------------+---------------------------------------------
//  tick      | tick_valid   | tick_stall   | rt_delta, bg0_delta, bg1_delta
//  result    | result_valid | result_stall | stop_pulse, resume_pulse, quota_hit,
//            |              |              | throttled_now, task_quota_now, budget_left_now
//  config    | cfg_we       | (none)       | cfg_index, cfg_wdata
//
// one beat per cycle sustained while result_stall is low; a tick beat goes from the input
// register through one pass of logic into the result register. the accumulator, budget and
// mode update is a single pass of saturating adders, a three-way sum and a subtract, so it
// closes through the state registers alone. reset (arst_n low) empties both registers, clears the
// accumulators and loads the config reset values into budget and quota. a stalled result
// holds; the input register still takes one more tick behind it, and tick_stall rises only
// when both are full.
`include "assert_macros.svh"

module memory_bandwidth_regulator_unit (
	input  logic               clk,
	input  logic               arst_n,
	// tick channel
	input  logic               tick_valid,
	output logic               tick_stall,
	input  mbr_pkg::delta_t    rt_delta,
	input  mbr_pkg::delta_t    bg0_delta,
	input  mbr_pkg::delta_t    bg1_delta,
	// result channel
	output logic               result_valid,
	input  logic               result_stall,
	output logic               stop_pulse,
	output logic               resume_pulse,
	output logic               quota_hit,
	output logic               throttled_now,
	output mbr_pkg::quota_t    task_quota_now,
	output mbr_pkg::budget_t   budget_left_now,
	// config write port
	input  logic               cfg_we,
	input  mbr_pkg::cfg_idx_t  cfg_index,
	input  mbr_pkg::cfg_data_t cfg_wdata
);
	import mbr_pkg::*;

	// width of the three-way accumulator sum and of the budget difference
	localparam int TOT_W  = ACCUM_W + 2;
	localparam int DIFF_W = ((TOT_W > BUDGET_W) ? TOT_W : BUDGET_W) + 1;
	localparam int CMP_W  = (ACCUM_W > QUOTA_W) ? ACCUM_W : QUOTA_W;
	localparam int PROD_W = QUOTA_SHIFT + QUOTA_W;
	localparam budget_t BUDGET_MIN = {1'b1, {(BUDGET_W-1){1'b0}}};

	// config registers
	cfg_data_t window_budget_q;
	cfg_data_t reserve_thresh_q;
	quota_t    initial_quota_q;

	// regulator state
	accum_t  rt_total_q;
	accum_t  bg0_total_q;
	accum_t  bg1_total_q;
	budget_t budget_left_q;
	quota_t  task_quota_q;
	logic    throttled_q;

	// input register
	logic   valid_s1;
	delta_t rt_delta_s1;
	delta_t bg0_delta_s1;
	delta_t bg1_delta_s1;

	// result register
	logic    result_valid_q;
	logic    stop_q;
	logic    resume_q;
	logic    hit_q;
	logic    thr_out_q;
	quota_t  quota_out_q;
	budget_t budget_out_q;

	// handshake
	logic out_free;
	logic advance;
	logic tick_take;

	// datapath
	accum_t                    rt_sum;
	accum_t                    bg0_sum;
	accum_t                    bg1_sum;
	logic [TOT_W-1:0]          total_sum;
	logic signed [DIFF_W-1:0]  diff;
	budget_t                   budget_sub;
	budget_t                   reserve_ext;
	logic                      any_hit;
	logic [PROD_W-1:0]         quota_prod;
	quota_t                    quota_third;

	// next state
	accum_t  rt_nx;
	accum_t  bg0_nx;
	accum_t  bg1_nx;
	budget_t budget_nx;
	quota_t  quota_nx;
	logic    thr_nx;
	logic    stop_nx;
	logic    resume_nx;
	logic    hit_nx;

	// assertion helpers
	logic                      res_stop;
	logic                      res_resume;
	logic                      restore_ok;
	logic [BUDGET_W+QUOTA_W:0] state_vec;

	// result register is free when empty or being drained this cycle
	assign out_free   = !result_valid_q || !result_stall;
	assign advance    = valid_s1 && out_free;
	assign tick_stall = valid_s1 && !out_free;
	assign tick_take  = tick_valid && !tick_stall;

	// config writes, unknown indexes dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_budget_q  <= RST_WINDOW_BUDGET;
			reserve_thresh_q <= RST_RESERVE_THRESH;
			initial_quota_q  <= RST_INITIAL_QUOTA;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WINDOW_BUDGET:  window_budget_q  <= cfg_wdata;
				REG_RESERVE_THRESH: reserve_thresh_q <= cfg_wdata;
				REG_INITIAL_QUOTA:  initial_quota_q  <= QUOTA_W'(cfg_wdata);
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (tick_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tick_take) begin
			rt_delta_s1  <= rt_delta;
			bg0_delta_s1 <= bg0_delta;
			bg1_delta_s1 <= bg1_delta;
		end
	end

	// accumulate, then charge all three running totals against the budget
	always_comb begin
		rt_sum      = sat_add(rt_total_q, rt_delta_s1);
		bg0_sum     = sat_add(bg0_total_q, bg0_delta_s1);
		bg1_sum     = sat_add(bg1_total_q, bg1_delta_s1);
		total_sum   = TOT_W'(rt_sum) + TOT_W'(bg0_sum) + TOT_W'(bg1_sum);
		diff        = DIFF_W'(budget_left_q) - signed'(DIFF_W'(total_sum));
		// budget floors at the most negative 48 bit value
		if (diff < DIFF_W'(BUDGET_MIN)) begin
			budget_sub = BUDGET_MIN;
		end else begin
			budget_sub = BUDGET_W'(diff);
		end
		reserve_ext = signed'(BUDGET_W'(reserve_thresh_q));
		any_hit     = (CMP_W'(rt_sum)  >= CMP_W'(task_quota_q))
		           || (CMP_W'(bg0_sum) >= CMP_W'(task_quota_q))
		           || (CMP_W'(bg1_sum) >= CMP_W'(task_quota_q));
		// quota / 3 by reciprocal multiply, off the budget path
		quota_prod  = PROD_W'(task_quota_q) * PROD_W'(QUOTA_RECIP);
		quota_third = quota_prod[PROD_W-1 -: QUOTA_W];
	end

	// mode control
	always_comb begin
		rt_nx     = rt_sum;
		bg0_nx    = bg0_sum;
		bg1_nx    = bg1_sum;
		budget_nx = budget_sub;
		quota_nx  = task_quota_q;
		thr_nx    = throttled_q;
		stop_nx   = 1'b0;
		resume_nx = 1'b0;
		hit_nx    = 1'b0;
		if (!throttled_q) begin
			// normal: a quota hit shrinks the quota and opens a new accounting round
			if (any_hit) begin
				hit_nx   = 1'b1;
				quota_nx = quota_third;
				rt_nx    = '0;
				bg0_nx   = '0;
				bg1_nx   = '0;
				// little budget left: stop the background tasks
				if (budget_sub <= reserve_ext) begin
					stop_nx = 1'b1;
					thr_nx  = 1'b1;
				end
			end
		end else if (budget_sub[BUDGET_W-1] || budget_sub == '0) begin
			// throttled and budget spent: new window
			resume_nx = 1'b1;
			thr_nx    = 1'b0;
			rt_nx     = '0;
			bg0_nx    = '0;
			bg1_nx    = '0;
			quota_nx  = initial_quota_q;
			budget_nx = signed'(BUDGET_W'(window_budget_q));
		end
	end

	// state update once per tick moving into the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rt_total_q    <= '0;
			bg0_total_q   <= '0;
			bg1_total_q   <= '0;
			budget_left_q <= signed'(BUDGET_W'(RST_WINDOW_BUDGET));
			task_quota_q  <= RST_INITIAL_QUOTA;
			throttled_q   <= 1'b0;
		end else if (advance) begin
			rt_total_q    <= rt_nx;
			bg0_total_q   <= bg0_nx;
			bg1_total_q   <= bg1_nx;
			budget_left_q <= budget_nx;
			task_quota_q  <= quota_nx;
			throttled_q   <= thr_nx;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			stop_q       <= stop_nx;
			resume_q     <= resume_nx;
			hit_q        <= hit_nx;
			thr_out_q    <= thr_nx;
			quota_out_q  <= quota_nx;
			budget_out_q <= budget_nx;
		end
	end

	assign result_valid    = result_valid_q;
	assign stop_pulse      = stop_q;
	assign resume_pulse    = resume_q;
	assign quota_hit       = hit_q;
	assign throttled_now   = thr_out_q;
	assign task_quota_now  = quota_out_q;
	assign budget_left_now = budget_out_q;

	assign res_stop   = result_valid_q && stop_q;
	assign res_resume = result_valid_q && resume_q;
	assign restore_ok = !thr_out_q && (quota_out_q == initial_quota_q);
	assign state_vec  = {throttled_q, budget_left_q, task_quota_q};

	// stop and resume come from different modes
	`ASSERT_ALWAYS(a_pulse_excl, !(res_stop && resume_q), "stop and resume together")
	// a stop only follows a quota hit and leaves the block throttled
	`ASSERT_IMPLY(a_stop_mode, res_stop, hit_q && thr_out_q, "stop without hit or throttle")
	// a resume restores normal mode and the initial quota
	`ASSERT_IMPLY(a_resume_restore, res_resume, restore_ok, "resume without window restore")
	// regulator state only moves with a tick
	`ASSERT_NEXT(a_state_hold, !advance, $stable(state_vec), "state changed without a tick")

endmodule
